>>> hdl/rgb_hsl_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSL package
// Shared types and constants for the pixel converter and its division cells.
// ----------------------------------------------------------------------------
package rgb_hsl_pkg;

  localparam int unsigned CompW = 8;
  localparam int unsigned SumW  = 9;
  localparam int unsigned OutW  = 16;
  localparam int unsigned SatW  = 8;
  localparam int unsigned HueW  = 11;

  localparam logic [CompW-1:0] CompMax = 8'd255;

  typedef logic [CompW-1:0] comp_t;

  // Payload handed from cell to cell: two restoring divisions run side by side.
  typedef struct packed {
    logic [SatW-1:0] sat_rem;
    logic [SatW-1:0] sat_den;
    logic [OutW-1:0] sat_quo;
    logic [HueW-1:0] hue_rem;
    logic [HueW-1:0] hue_den;
    logic [OutW-1:0] hue_quo;
    logic [SumW-1:0] sum;
  } div_t;

endpackage

>>> hdl/rgb_hsl_if.sv
// ----------------------------------------------------------------------------
// RGB to HSL channels
// Valid/ready channels for input pixels and HSL results.
// ----------------------------------------------------------------------------
interface rgb_hsl_pix_if;
  logic                        valid;
  logic                        ready;
  logic [rgb_hsl_pkg::CompW-1:0] red;
  logic [rgb_hsl_pkg::CompW-1:0] green;
  logic [rgb_hsl_pkg::CompW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgb_hsl_res_if;
  logic                         valid;
  logic                         ready;
  logic [rgb_hsl_pkg::OutW-1:0] hue;
  logic [rgb_hsl_pkg::OutW-1:0] saturation;
  logic [rgb_hsl_pkg::SumW-1:0] lightness_sum;

  modport source (output valid, output hue, output saturation, output lightness_sum,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness_sum,
                  output ready);
endinterface

>>> hdl/rgb_hsl_prep.sv
// ----------------------------------------------------------------------------
// RGB to HSL front stage
// Finds max and min, forms lightness sum and both division operands.
// ----------------------------------------------------------------------------
module rgb_hsl_prep (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [rgb_hsl_pkg::CompW-1:0] red_i,
  input  logic [rgb_hsl_pkg::CompW-1:0] green_i,
  input  logic [rgb_hsl_pkg::CompW-1:0] blue_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output rgb_hsl_pkg::div_t        data_o
);
  import rgb_hsl_pkg::*;

  comp_t            mx, mn, delta;
  logic [SumW-1:0]  sum;
  logic [SumW-1:0]  sat_den_w;
  logic signed [12:0] base, diff, num;
  logic [HueW-1:0]  den6;
  logic             grey;
  logic             valid_q;
  div_t             data_d, data_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i  > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i  < mn) mn = blue_i;
    delta = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};
    grey  = (delta == '0);

    sat_den_w = (sum < {1'b0, CompMax}) ? sum : (9'd510 - sum);
    den6      = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};

    if (red_i == mx) begin
      base = '0;
      diff = $signed({5'd0, green_i}) - $signed({5'd0, blue_i});
    end else if (green_i == mx) begin
      base = $signed({4'd0, delta, 1'b0});
      diff = $signed({5'd0, blue_i}) - $signed({5'd0, red_i});
    end else begin
      base = $signed({3'd0, delta, 2'b00});
      diff = $signed({5'd0, red_i}) - $signed({5'd0, green_i});
    end
    num = base + diff;
    if (num < 0) num = num + $signed({2'b00, den6});

    data_d.sum     = sum;
    data_d.sat_quo = '0;
    data_d.hue_quo = '0;
    if (grey) begin
      data_d.sat_rem = '0;
      data_d.sat_den = SatW'(1);
      data_d.hue_rem = '0;
      data_d.hue_den = HueW'(1);
    end else begin
      data_d.sat_rem = delta;
      data_d.sat_den = sat_den_w[SatW-1:0];
      data_d.hue_rem = num[HueW-1:0];
      data_d.hue_den = den6;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

>>> hdl/rgb_hsl_cell.sv
// ----------------------------------------------------------------------------
// RGB to HSL division cell
// One restoring step for saturation and hue; yields one quotient bit each.
// ----------------------------------------------------------------------------
module rgb_hsl_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  rgb_hsl_pkg::div_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output rgb_hsl_pkg::div_t data_o
);
  import rgb_hsl_pkg::*;

  logic [SatW:0] sat_shl;
  logic [HueW:0] hue_shl;
  logic          sat_bit, hue_bit;
  logic [SatW:0] sat_sub;
  logic [HueW:0] hue_sub;
  logic          valid_q;
  div_t          data_d, data_q;

  always_comb begin
    sat_shl = {data_i.sat_rem, 1'b0};
    hue_shl = {data_i.hue_rem, 1'b0};
    sat_bit = (sat_shl >= {1'b0, data_i.sat_den});
    hue_bit = (hue_shl >= {1'b0, data_i.hue_den});
    sat_sub = sat_bit ? (sat_shl - {1'b0, data_i.sat_den}) : sat_shl;
    hue_sub = hue_bit ? (hue_shl - {1'b0, data_i.hue_den}) : hue_shl;

    data_d         = data_i;
    data_d.sat_rem = sat_sub[SatW-1:0];
    data_d.hue_rem = hue_sub[HueW-1:0];
    data_d.sat_quo = {data_i.sat_quo[OutW-2:0], sat_bit};
    data_d.hue_quo = {data_i.hue_quo[OutW-2:0], hue_bit};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

>>> hdl/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Throughput: one pixel per cycle while hsl_o.ready is high; a row of
// FRAC_BITS division cells, each producing one quotient bit of hue and
// saturation, follows the registered front stage.
// Reset clears all stage valid bits; the chain is empty after reset.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rgb_hsl_pix_if.sink          pix_i,
  rgb_hsl_res_if.source        hsl_o
);
  import rgb_hsl_pkg::*;

  logic  stg_valid [FRAC_BITS+1];
  logic  stg_ready [FRAC_BITS+1];
  div_t  stg_data  [FRAC_BITS+1];

  rgb_hsl_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_i.valid),
    .ready_o (pix_i.ready),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .data_o  (stg_data[0])
  );

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_cell
    rgb_hsl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k]),
      .ready_o (stg_ready[k]),
      .data_i  (stg_data[k]),
      .valid_o (stg_valid[k+1]),
      .ready_i (stg_ready[k+1]),
      .data_o  (stg_data[k+1])
    );
  end

  assign stg_ready[FRAC_BITS] = hsl_o.ready;
  assign hsl_o.valid          = stg_valid[FRAC_BITS];
  assign hsl_o.hue            = stg_data[FRAC_BITS].hue_quo;
  assign hsl_o.saturation     = stg_data[FRAC_BITS].sat_quo;
  assign hsl_o.lightness_sum  = stg_data[FRAC_BITS].sum;

endmodule

>>> hdl/rgb_hsl_chk.sv
// ----------------------------------------------------------------------------
// RGB to HSL port checker
// Watches the result channel of the converter over time.
// ----------------------------------------------------------------------------
module rgb_hsl_chk (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [rgb_hsl_pkg::OutW-1:0] hue_i,
  input  logic [rgb_hsl_pkg::OutW-1:0] sat_i,
  input  logic [rgb_hsl_pkg::SumW-1:0] lsum_i
);
  import rgb_hsl_pkg::*;

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result beat shown during reset");

  a_hold_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(hue_i) && $stable(sat_i)
      && $stable(lsum_i))
    else $error("stalled result beat changed");

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> lsum_i <= 9'd510)
    else $error("lightness sum out of range");

  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && sat_i == '0 |-> hue_i == '0)
    else $error("grey pixel with nonzero hue");

endmodule

bind rgb_to_hsl_converter rgb_hsl_chk u_rgb_hsl_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (hsl_o.valid),
  .out_ready_i (hsl_o.ready),
  .hue_i       (hsl_o.hue),
  .sat_i       (hsl_o.saturation),
  .lsum_i      (hsl_o.lightness_sum)
);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter testbench
// Drives 8-bit RGB pixels through the valid/ready input channel and checks
// each HSL result beat, in order, against a fixed-point predictor of hue,
// saturation and lightness sum. A directed table of extremes, primaries,
// ties and grey pixels runs first, then random pixels with bursts of idling
// on both sides, one long result hold-off and one drain pause.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rgb_hsl_pkg::*;

  localparam int unsigned FracBits     = 16;
  localparam int unsigned RandomPixels = 1200;
  localparam int unsigned QuietPixels  = 200;
  localparam int unsigned HoldAtPixel  = 300;
  localparam int unsigned PauseAtPixel = 600;
  localparam int unsigned HoldCycles   = 120;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned CycleLimit   = 200000;

  typedef struct packed {
    logic [OutW-1:0] hue;
    logic [OutW-1:0] saturation;
    logic [SumW-1:0] lightness_sum;
  } hsl_t;

  typedef struct packed {
    comp_t red;
    comp_t green;
    comp_t blue;
    logic  known;
    hsl_t  hsl;
  } pixel_row_t;

  localparam hsl_t NoHsl = '0;

  localparam pixel_row_t DirectedRows [24] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{16'd0,     16'd0,     9'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{16'd0,     16'd0,     9'd510}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{16'd0,     16'd0,     9'd256}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{16'd0,     16'd65535, 9'd255}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{16'd21845, 16'd65535, 9'd255}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{16'd43690, 16'd65535, 9'd255}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{16'd10922, 16'd65535, 9'd255}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{16'd32768, 16'd65535, 9'd255}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{16'd54613, 16'd65535, 9'd255}},
    '{8'd1,   8'd0,   8'd0,   1'b1, '{16'd0,     16'd65535, 9'd1}},
    '{8'd254, 8'd0,   8'd0,   1'b1, '{16'd0,     16'd65535, 9'd254}},
    '{8'd255, 8'd1,   8'd0,   1'b0, NoHsl},
    '{8'd255, 8'd254, 8'd254, 1'b0, NoHsl},
    '{8'd255, 8'd254, 8'd255, 1'b0, NoHsl},
    '{8'd255, 8'd0,   8'd1,   1'b0, NoHsl},
    '{8'd128, 8'd127, 8'd127, 1'b0, NoHsl},
    '{8'd1,   8'd2,   8'd3,   1'b0, NoHsl},
    '{8'd200, 8'd100, 8'd50,  1'b0, NoHsl},
    '{8'd10,  8'd20,  8'd10,  1'b0, NoHsl},
    '{8'd127, 8'd128, 8'd0,   1'b0, NoHsl},
    '{8'd0,   8'd1,   8'd255, 1'b0, NoHsl},
    '{8'd254, 8'd255, 8'd253, 1'b0, NoHsl},
    '{8'd0,   8'd128, 8'd255, 1'b0, NoHsl},
    '{8'd64,  8'd0,   8'd64,  1'b0, NoHsl}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        row_known;
  hsl_t        row_hsl;
  logic        idling_on;
  logic        hold_off_req;
  int unsigned mismatches;
  int unsigned cycle_count;
  hsl_t        expected_hsl [$];
  hsl_t        head_hsl;

  rgb_hsl_pix_if pix_if ();
  rgb_hsl_res_if hsl_if ();

  rgb_to_hsl_converter #(
    .FRAC_BITS(FracBits)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_if),
    .hsl_o (hsl_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic hsl_t hsl_of_pixel(comp_t r, comp_t g, comp_t b);
    int unsigned     mx;
    int unsigned     mn;
    int unsigned     delta;
    int unsigned     sum;
    int unsigned     den;
    int              n;
    int              den6;
    longint unsigned full_q;
    longint unsigned q;
    hsl_t            res;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    sum = mx + mn;
    full_q = (64'd1 << FracBits) - 64'd1;
    res.hue = '0;
    res.saturation = '0;
    res.lightness_sum = sum[SumW-1:0];
    if (delta != 0) begin
      den = (sum < CompMax) ? sum : 2 * CompMax - sum;
      q = (64'(delta) << FracBits) / 64'(den);
      if (q > full_q) q = full_q;
      res.saturation = q[OutW-1:0];
      if (r == mx) begin
        n = int'(g) - int'(b);
      end else if (g == mx) begin
        n = 2 * int'(delta) + int'(b) - int'(r);
      end else begin
        n = 4 * int'(delta) + int'(r) - int'(g);
      end
      den6 = 6 * int'(delta);
      if (n < 0) n += den6;
      q = (64'(n) << FracBits) / 64'(den6);
      if (q > full_q) q = full_q;
      res.hue = q[OutW-1:0];
    end
    return res;
  endfunction

  task automatic send_pixel(comp_t r, comp_t g, comp_t b, logic known, hsl_t want);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      pix_if.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    pix_if.valid = 1'b1;
    pix_if.red   = r;
    pix_if.green = g;
    pix_if.blue  = b;
    row_known    = known;
    row_hsl      = want;
    do @(posedge clk_i); while (!pix_if.ready);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) begin
        expected_hsl.push_back(row_known ? row_hsl :
                               hsl_of_pixel(pix_if.red, pix_if.green, pix_if.blue));
      end
      if (hsl_if.valid && hsl_if.ready) begin
        if (expected_hsl.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual %h %h %h", $time,
                   hsl_if.hue, hsl_if.saturation, hsl_if.lightness_sum);
          mismatches++;
        end else begin
          head_hsl = expected_hsl.pop_front();
          if (hsl_if.hue !== head_hsl.hue) begin
            $display("%0t: hue mismatch, expected %0d actual %0d", $time,
                     head_hsl.hue, hsl_if.hue);
            mismatches++;
          end
          if (hsl_if.saturation !== head_hsl.saturation) begin
            $display("%0t: saturation mismatch, expected %0d actual %0d", $time,
                     head_hsl.saturation, hsl_if.saturation);
            mismatches++;
          end
          if (hsl_if.lightness_sum !== head_hsl.lightness_sum) begin
            $display("%0t: lightness_sum mismatch, expected %0d actual %0d", $time,
                     head_hsl.lightness_sum, hsl_if.lightness_sum);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    hsl_if.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hsl_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
        hsl_if.ready = 1'b1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        hsl_if.ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        hsl_if.ready = 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    comp_t       rv;
    comp_t       gv;
    comp_t       bv;
    int unsigned pick;
    pix_if.valid = 1'b0;
    pix_if.red   = '0;
    pix_if.green = '0;
    pix_if.blue  = '0;
    row_known    = 1'b0;
    row_hsl      = NoHsl;
    idling_on    = 1'b1;
    hold_off_req = 1'b0;
    mismatches   = 0;
    rst_ni       = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirectedRows[i]) begin
      send_pixel(DirectedRows[i].red, DirectedRows[i].green, DirectedRows[i].blue,
                 DirectedRows[i].known, DirectedRows[i].hsl);
    end

    for (int i = 0; i < RandomPixels; i++) begin
      if (i == HoldAtPixel) hold_off_req = 1'b1;
      if (i == PauseAtPixel) begin
        pix_if.valid = 1'b0;
        while (expected_hsl.size() != 0) @(negedge clk_i);
      end
      if (i == RandomPixels - QuietPixels) idling_on = 1'b0;
      rv = comp_t'($urandom);
      gv = comp_t'($urandom);
      bv = comp_t'($urandom);
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          gv = rv;
          bv = rv;
        end
        1: gv = rv;
        2: bv = gv;
        3: bv = rv;
        4: begin
          gv = rv + comp_t'($urandom_range(0, 1));
          bv = rv - comp_t'($urandom_range(0, 1));
        end
        5: begin
          rv = $urandom_range(0, 1) ? CompMax : '0;
          gv = $urandom_range(0, 1) ? CompMax : '0;
          bv = $urandom_range(0, 1) ? CompMax : '0;
        end
        default: ;
      endcase
      send_pixel(rv, gv, bv, 1'b0, NoHsl);
    end

    pix_if.valid = 1'b0;
    while (expected_hsl.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
